@@ rtl/core/zzrt_pkg.sv @@
// zzrt_pkg: widths, constants and controller/datapath interface types
// for the zigzag row transposer. No dependencies.
`default_nettype none

package zzrt_pkg;

    localparam int CHAR_W   = 8;   // message byte
    localparam int ROWS_W   = 7;   // num_rows register
    localparam int RAIL_W   = 6;   // zigzag row number
    localparam int RAIL_NUM = 64;  // rows that can ever hold a byte
    localparam int ROWS_MAX = 64;  // num_rows saturates here

    // controller -> datapath
    typedef struct packed {
        logic load;      // input item accepted this cycle
        logic link;      // append stored byte to its row list
        logic em_start;  // fetch first byte of the output sequence
        logic em_step;   // output item accepted this cycle
        logic sel_emit;  // row list reads follow the emit side
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic msg_last;    // item just loaded closes the message
        logic final_item;  // item on the output is the last of the message
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/zigzag_row_transposer.sv @@
// Zigzag (rail fence) row transposer, top level. Each byte is loaded in an
// accept cycle that writes the byte store, then a link cycle that
// appends it to its row list. After the last byte's link cycle comes a fetch
// cycle, then one result per cycle while the output is taken. Rows are
// walked through head/tail/next lists. Reset clears control state only; stores are not swept.
`default_nettype none

module zigzag_row_transposer #(
    parameter int MAX_LEN = 64
) (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    input  wire  logic                        i_in_valid,
    output logic                              o_in_ready,
    input  wire  logic [zzrt_pkg::CHAR_W-1:0] i_char_in,
    input  wire  logic                        i_last_char,
    output logic                              o_out_valid,
    input  wire  logic                        i_out_ready,
    output logic [zzrt_pkg::CHAR_W-1:0]       o_char_out,
    output logic                              o_last_out,
    output logic                              o_overflowed,
    input  wire  logic                        i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  logic [zzrt_pkg::ROWS_W-1:0] i_cfg_data
);

    zzrt_pkg::t_dp_cmd dp_cmd;
    zzrt_pkg::t_dp_sts dp_sts;

    // num_rows is a plain register: always writable
    assign o_cfg_ready = 1'b1;

    zzrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    zzrt_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_char_in    (i_char_in),
        .i_last_char  (i_last_char),
        .o_char_out   (o_char_out),
        .o_last_out   (o_last_out),
        .o_overflowed (o_overflowed)
    );

endmodule

`default_nettype wire

@@ rtl/core/zzrt_ctrl.sv @@
// zzrt_ctrl: handshake controller of the zigzag row transposer.
// Drives zzrt_dp through zzrt_pkg::t_dp_cmd and reads zzrt_pkg::t_dp_sts.
`default_nettype none

module zzrt_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire                logic i_out_ready,
    input  wire zzrt_pkg::t_dp_sts  i_sts,
    output zzrt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_EM_RD,
        S_EM_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load     = r_in_ready & i_in_valid;
        o_cmd.link     = (r_state == S_LINK);
        o_cmd.em_start = (r_state == S_EM_RD);
        o_cmd.em_step  = r_out_valid & i_out_ready;
        o_cmd.sel_emit = (r_state == S_EM_RD) || (r_state == S_EM_OUT);
    end

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state    = S_LINK;
                    n_in_ready = 1'b0;
                end
            end
            S_LINK: begin
                if (i_sts.msg_last) begin
                    n_state = S_EM_RD;
                end else begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            S_EM_RD: begin
                n_state     = S_EM_OUT;
                n_out_valid = 1'b1;
            end
            S_EM_OUT: begin
                // stream: the next byte is fetched on each accepted item
                if (o_cmd.em_step && i_sts.final_item) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                    n_in_ready  = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_in_ready  = 1'b1;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input and output sides open at once");

    a_load_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_LINK))
        else $error("accepted item not linked in the next cycle");

    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.em_step && i_sts.final_item) |=> (r_in_ready && !r_out_valid))
        else $error("block not ready after the last output item");

endmodule

`default_nettype wire

@@ rtl/core/zzrt_dp.sv @@
// zzrt_dp: byte store, per-row linked lists and output register of the
// zigzag row transposer. Uses zzrt_pkg; commanded by zzrt_ctrl.
`default_nettype none

module zzrt_dp #(
    parameter int MAX_LEN = 64
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire zzrt_pkg::t_dp_cmd  i_cmd,
    output zzrt_pkg::t_dp_sts  o_sts,
    input  wire                logic i_cfg_we,
    input  wire                logic [zzrt_pkg::ROWS_W-1:0] i_cfg_data,
    input  wire                logic [zzrt_pkg::CHAR_W-1:0] i_char_in,
    input  wire                logic i_last_char,
    output logic [zzrt_pkg::CHAR_W-1:0] o_char_out,
    output logic               o_last_out,
    output logic               o_overflowed
);

    localparam int IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int CMPW = (CW > zzrt_pkg::ROWS_W) ? CW : zzrt_pkg::ROWS_W;
    localparam logic [CW-1:0] CountMax = CW'(MAX_LEN);

    // storage
    logic [zzrt_pkg::CHAR_W-1:0] byte_mem [MAX_LEN];
    logic [IW-1:0]               next_mem [MAX_LEN];
    logic [IW-1:0]               head_mem [zzrt_pkg::RAIL_NUM];
    logic [IW-1:0]               tail_mem [zzrt_pkg::RAIL_NUM];

    // message state
    logic [zzrt_pkg::ROWS_W-1:0] r_num_rows;
    logic [CW-1:0]               r_count;
    logic [zzrt_pkg::RAIL_W-1:0] r_rail;
    logic                        r_heading;
    logic                        r_drop;
    logic [zzrt_pkg::RAIL_W-1:0] r_max_rail;

    // latched at load, used while linking and emitting
    logic                        r_stored, r_new, r_last, r_pass;
    logic [IW-1:0]               r_idx;
    logic [zzrt_pkg::RAIL_W-1:0] r_lrail;

    // emit side
    logic [zzrt_pkg::RAIL_W-1:0] r_emit_rail, n_emit_rail;
    logic [CW-1:0]               r_left;
    logic [IW-1:0]               r_addr;
    logic [IW-1:0]               r_tail_rd, r_head_rd, r_next_rd;
    logic [zzrt_pkg::CHAR_W-1:0] r_char;

    logic [zzrt_pkg::ROWS_W-1:0] rows_eff;
    logic                        stored, new_rail, turn_up, heading_nx, pass_nx;
    logic [CW-1:0]               count_nx;
    logic [zzrt_pkg::RAIL_W-1:0] rail_nx, tail_addr, head_addr;
    logic                        final_item, eor, clr, rd_en, advance;
    logic [IW-1:0]               rd_addr;

    // load side: zigzag step and pass-through test
    always_comb begin
        if (r_num_rows == '0) begin
            rows_eff = zzrt_pkg::ROWS_W'(1);
        end else if (r_num_rows > zzrt_pkg::ROWS_W'(zzrt_pkg::ROWS_MAX)) begin
            rows_eff = zzrt_pkg::ROWS_W'(zzrt_pkg::ROWS_MAX);
        end else begin
            rows_eff = r_num_rows;
        end
        stored   = (r_count < CountMax);
        count_nx = stored ? (r_count + CW'(1)) : r_count;
        new_rail = (r_count == '0) || (r_rail > r_max_rail);
        pass_nx  = (rows_eff <= zzrt_pkg::ROWS_W'(1)) ||
                   (CMPW'(count_nx) <= CMPW'(rows_eff));
        turn_up  = ({1'b0, r_rail} >= (rows_eff - zzrt_pkg::ROWS_W'(1)));
        if (r_rail == '0) begin
            heading_nx = 1'b1;
        end else if (turn_up) begin
            heading_nx = 1'b0;
        end else begin
            heading_nx = r_heading;
        end
        if (rows_eff <= zzrt_pkg::ROWS_W'(1)) begin
            rail_nx = '0;
        end else if (heading_nx) begin
            rail_nx = r_rail + zzrt_pkg::RAIL_W'(1);
        end else begin
            rail_nx = r_rail - zzrt_pkg::RAIL_W'(1);
        end
    end

    // emit side: walk rows in ascending order, each row's list in arrival order (pass-through: store in address order)
    always_comb begin
        final_item = (r_left == CW'(1));
        eor        = (r_addr == r_tail_rd);
        clr        = i_cmd.em_step & final_item;
        rd_en      = i_cmd.em_start | (i_cmd.em_step & ~final_item);
        advance    = ~r_pass & (i_cmd.em_start | (i_cmd.em_step & ~final_item & eor));
        if (i_cmd.em_start) begin
            rd_addr = r_pass ? '0 : r_head_rd;
        end else if (r_pass) begin
            rd_addr = r_addr + IW'(1);
        end else begin
            rd_addr = eor ? r_head_rd : r_next_rd;
        end
        if (clr) begin
            n_emit_rail = '1;
        end else if (advance) begin
            n_emit_rail = r_emit_rail + zzrt_pkg::RAIL_W'(1);
        end else begin
            n_emit_rail = r_emit_rail;
        end
        // tail read port tracks the row the next cycle works on, head read port the row after it
        tail_addr = i_cmd.sel_emit ? n_emit_rail : r_rail;
        head_addr = n_emit_rail + zzrt_pkg::RAIL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= zzrt_pkg::ROWS_W'(1);
            r_count     <= '0;
            r_rail      <= '0;
            r_heading   <= 1'b0;
            r_drop      <= 1'b0;
            r_max_rail  <= '0;
            r_stored    <= 1'b0;
            r_new       <= 1'b0;
            r_last      <= 1'b0;
            r_pass      <= 1'b0;
            r_emit_rail <= '1;
            r_left      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num_rows <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_stored <= stored;
                r_new    <= new_rail;
                r_last   <= i_last_char;
                r_pass   <= pass_nx;
                if (stored) begin
                    r_count   <= count_nx;
                    r_rail    <= rail_nx;
                    r_heading <= (rows_eff <= zzrt_pkg::ROWS_W'(1)) ? 1'b0 : heading_nx;
                    if (new_rail) begin
                        r_max_rail <= r_rail;
                    end
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.em_start) begin
                r_left <= r_count;
            end else if (i_cmd.em_step) begin
                r_left <= r_left - CW'(1);
            end
            r_emit_rail <= n_emit_rail;
            // drop the finished message
            if (clr) begin
                r_count   <= '0;
                r_rail    <= '0;
                r_heading <= 1'b0;
                r_drop    <= 1'b0;
                r_last    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= r_count[IW-1:0];
            r_lrail <= r_rail;
        end
        if (rd_en) begin
            r_addr <= rd_addr;
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && stored) begin
            byte_mem[r_count[IW-1:0]] <= i_char_in;
        end
        if (rd_en) begin
            r_char <= byte_mem[rd_addr];
        end
    end

    // successor of each byte within its row
    always_ff @(posedge i_clk) begin
        if (i_cmd.link && r_stored && !r_new) begin
            next_mem[r_tail_rd] <= r_idx;
        end
        if (rd_en) begin
            r_next_rd <= next_mem[rd_addr];
        end
    end

    // first byte of each row
    always_ff @(posedge i_clk) begin
        if (i_cmd.link && r_stored && r_new) begin
            head_mem[r_lrail] <= r_idx;
        end
        r_head_rd <= head_mem[head_addr];
    end

    // latest byte of each row
    always_ff @(posedge i_clk) begin
        if (i_cmd.link && r_stored) begin
            tail_mem[r_lrail] <= r_idx;
        end
        r_tail_rd <= tail_mem[tail_addr];
    end

    always_comb begin
        o_sts.msg_last   = r_last;
        o_sts.final_item = final_item;
    end

    assign o_char_out   = r_char;
    assign o_last_out   = final_item;
    assign o_overflowed = r_drop;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.em_step |-> (r_left != '0))
        else $error("output item taken with nothing left to send");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_count <= CountMax))
        else $error("byte count beyond capacity");

    a_link_known_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.link && r_stored && !r_new) |-> (r_lrail <= r_max_rail))
        else $error("append to a row that has no list yet");

endmodule

`default_nettype wire

@@ verif/rail_fence_checker.sv @@
// rail_fence_checker: watches the input, output and config channels of
// zigzag_row_transposer, predicts the transposed bytes and compares them.
// Depends on zzrt_pkg for widths and row limits.
`timescale 1ns / 1ps

module rail_fence_checker #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [zzrt_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic                        i_last_char,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [zzrt_pkg::CHAR_W-1:0] i_char_out,
    input  wire logic                        i_last_out,
    input  wire logic                        i_overflowed,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [zzrt_pkg::ROWS_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [zzrt_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic                        ovf;
    } t_cipher_byte;

    t_cipher_byte cipher_q[$];
    t_cipher_byte due;

    logic [zzrt_pkg::CHAR_W-1:0] msg_byte [MAX_LEN];
    logic [zzrt_pkg::RAIL_W-1:0] msg_rail [MAX_LEN];
    logic [zzrt_pkg::ROWS_W-1:0] held;
    logic [zzrt_pkg::RAIL_W-1:0] rail;
    logic                        down;
    logic                        dropped;
    logic [zzrt_pkg::ROWS_W-1:0] rows_reg;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_message();
        held    = '0;
        rail    = '0;
        down    = 1'b0;
        dropped = 1'b0;
    endtask

    task automatic push_byte(input int idx);
        t_cipher_byte item;
        item.ch   = msg_byte[idx];
        item.last = 1'b0;
        item.ovf  = dropped;
        cipher_q.push_back(item);
    endtask

    // Store one byte on its rail; on the closing byte, queue the transposed message.
    task automatic absorb_byte(input logic [zzrt_pkg::CHAR_W-1:0] ch, input logic close);
        int n;
        int first;
        n = (rows_reg == 0) ? 1 : (rows_reg > zzrt_pkg::ROWS_MAX) ? zzrt_pkg::ROWS_MAX
                                                                  : int'(rows_reg);
        if (held < MAX_LEN) begin
            msg_byte[held] = ch;
            msg_rail[held] = rail;
            held++;
            if (n <= 1) begin
                rail = '0;
                down = 1'b0;
            end else begin
                if (rail == 0) down = 1'b1;
                else if (int'(rail) >= n - 1) down = 1'b0;
                rail = down ? rail + 1'b1 : rail - 1'b1;
            end
        end else begin
            dropped = 1'b1;
        end
        if (!close) return;
        first = cipher_q.size();
        if (n <= 1 || int'(held) <= n) begin
            for (int i = 0; i < int'(held); i++) push_byte(i);
        end else begin
            for (int r = 0; r < zzrt_pkg::RAIL_NUM; r++)
                for (int i = 0; i < int'(held); i++)
                    if (int'(msg_rail[i]) == r) push_byte(i);
        end
        if (cipher_q.size() > first) cipher_q[cipher_q.size() - 1].last = 1'b1;
        clear_message();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = 7'd1;
            clear_message();
            cipher_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) rows_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) absorb_byte(i_char_in, i_last_char);
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    flag_mismatch("item with no byte due", i_char_out, 0);
                end else begin
                    due = cipher_q.pop_front();
                    if (i_char_out !== due.ch) flag_mismatch("char_out", i_char_out, due.ch);
                    if (i_last_out !== due.last)
                        flag_mismatch("last_out", i_last_out, due.last);
                    if (i_overflowed !== due.ovf)
                        flag_mismatch("overflowed", i_overflowed, due.ovf);
                end
            end
        end
        o_pending <= cipher_q.size();
    end

endmodule

@@ verif/testbench.sv @@
// testbench: drives messages and num_rows settings into zigzag_row_transposer
// and gives the verdict. Depends on zzrt_pkg and rail_fence_checker.
`timescale 1ns / 1ps

module testbench;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [zzrt_pkg::CHAR_W-1:0] char_in;
    logic                        last_char;
    logic                        out_valid;
    logic                        out_ready;
    logic [zzrt_pkg::CHAR_W-1:0] char_out;
    logic                        last_out;
    logic                        overflowed;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [zzrt_pkg::ROWS_W-1:0] cfg_data;
    int                          fail_count;
    int                          pending;

    bit tx_calm;
    bit stall_rx;
    int random_bytes;

    zigzag_row_transposer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_char_in   (char_in),
        .i_last_char (last_char),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_char_out  (char_out),
        .o_last_out  (last_out),
        .o_overflowed(overflowed),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    rail_fence_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_char_in   (char_in),
        .i_last_char (last_char),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_char_out  (char_out),
        .i_last_out  (last_out),
        .i_overflowed(overflowed),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_byte(input logic [zzrt_pkg::CHAR_W-1:0] ch, input logic close);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= ch;
        last_char <= close;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_message(input int len, input logic close);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(0, 255)), close && (k == len - 1));
    endtask

    // Drop valid, wait out every queued result, then let the link cycle finish.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_rows(input logic [zzrt_pkg::ROWS_W-1:0] rows);
        cfg_valid <= 1'b1;
        cfg_data  <= rows;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Output side: random hold-offs per item, plus one long stall on request.
    initial begin
        int  gap;
        bit  calm;
        out_ready <= 1'b0;
        calm = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 10);
            if (stall_rx) begin
                stall_rx = 1'b0;
                gap = 400;
            end
            repeat (gap) begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int phase;
        int msgs;
        int len;
        logic [zzrt_pkg::ROWS_W-1:0] rows_pick;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_in   <= '0;
        last_char <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        tx_calm      = 1'b0;
        stall_rx     = 1'b0;
        random_bytes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rows of 1: bytes pass through, both extreme byte values.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        // Zero rows act as one; single-byte message.
        write_rows(7'd0);
        send_byte(8'hA5, 1'b1);
        settle();
        // Rows above the limit saturate; short message passes through.
        write_rows(7'd127);
        send_message(3, 1'b1);
        settle();
        write_rows(7'd2);
        send_message(5, 1'b1);
        settle();
        // Change rows mid-message: shrink below the current rail, drop to one, regrow.
        write_rows(7'd8);
        send_message(6, 1'b0);
        settle();
        write_rows(7'd3);
        send_message(3, 1'b0);
        settle();
        write_rows(7'd1);
        send_message(1, 1'b0);
        settle();
        write_rows(7'd4);
        send_message(2, 1'b1);
        settle();

        phase = 0;
        while (random_bytes < 200) begin
            case (phase % 8)
                0:       rows_pick = 7'd2;
                1:       rows_pick = 7'd3;
                2:       rows_pick = 7'd5;
                3:       rows_pick = 7'd64;
                4:       rows_pick = 7'd1;
                5:       rows_pick = 7'd0;
                6:       rows_pick = 7'd127;
                default: rows_pick = 7'($urandom_range(0, 127));
            endcase
            write_rows(rows_pick);
            msgs = $urandom_range(2, 5);
            if (phase == 2) stall_rx = 1'b1;
            for (int m = 0; m < msgs; m++) begin
                // Overflow: last byte lands beyond capacity and still closes the message.
                if (phase == 1 && m == 0) len = 66;
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(60, 70);
                else len = $urandom_range(1, 24);
                send_message(len, 1'b1);
                random_bytes += len;
            end
            settle();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
